// File: design/median_filter_3x3_interior_unit_macros.svh
// Assertion macros for the design file that checks its own logic.
`ifndef MEDIAN_FILTER_3X3_INTERIOR_UNIT_MACROS_SVH
`define MEDIAN_FILTER_3X3_INTERIOR_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define MF3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MF3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/mf3_pkg.sv
package mf3_pkg;

    localparam int IMAGE_WIDTH  = 16;
    localparam int IMAGE_HEIGHT = 16;

    localparam int PIX_W  = 8;
    localparam int TAPS   = 9;
    localparam int COL_W  = (IMAGE_WIDTH  > 1) ? $clog2(IMAGE_WIDTH)  : 1;
    localparam int ROW_W  = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;

    // One line buffer entry holds the pixel two rows up and the one a row up.
    localparam int LINE_W = 2 * PIX_W;

    typedef logic [PIX_W-1:0] t_pix;

    // A complete 3x3 window: taps 0..2 oldest column, 3..5 middle, 6..8 newest.
    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] taps;
        logic                       eof;
    } t_win;

endpackage

// File: design/median_filter_3x3_interior_unit.sv
// Channel   Direction  Handshake         Payload
// pixel     in         i_valid/o_stall   i_pixel (8-bit, raster order)
// median    out        o_valid/i_stall   o_median_value (8-bit), o_end_of_frame
//
// One pixel is taken per clock while o_stall is low; the line buffer memory is
// read and written once per pixel, which sets that rate. Reset clears the raster
// counters, the window columns and all valid flags; line buffer contents stay
// unknown until the first two rows of a frame have passed. A stall on the output
// first fills the bubbles of the compare pipeline and then reaches the input as
// o_stall.
module median_filter_3x3_interior_unit import mf3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_pix i_pixel,
    output logic o_valid,
    input  logic i_stall,
    output t_pix o_median_value,
    output logic o_end_of_frame
);

`include "median_filter_3x3_interior_unit_macros.svh"

    // The window builder tracks the raster position, keeps the two rows above in
    // one memory and hands every interior 3x3 window to the compare pipeline.
    logic win_valid;
    logic win_ready;
    t_win win;

    mf3_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel    (i_pixel),
        .o_win_valid(win_valid),
        .i_win_ready(win_ready),
        .o_win      (win)
    );

    // The compare pipeline sorts each column, then reduces the three sorted
    // columns to the fifth smallest value, and keeps it in an output register.
    mf3_median u_median (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win_valid   (win_valid),
        .o_win_ready   (win_ready),
        .i_win         (win),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_median_value(o_median_value),
        .o_end_of_frame(o_end_of_frame)
    );

    // Nothing is reported in the cycle after reset.
    `MF3_ASSERT_ALWAYS(a_no_out_after_reset, !i_rst_n |=> !o_valid, "output valid after reset")

    // With the output register empty, no back pressure can reach the input.
    `MF3_ASSERT(a_empty_no_stall, !o_valid |-> !o_stall, "input stalled with empty output")

    // The first pixel of a frame never completes a window.
    `MF3_ASSERT(a_frame_restart, win_valid && win_ready && win.eof |=> !win_valid,
                "window issued right after frame end")

endmodule

// File: design/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/mf3_window.sv
module mf3_window import mf3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_pix       i_pixel,
    output logic       o_win_valid,
    input  logic       i_win_ready,
    output t_win       o_win
);

    // Raster counters, advanced on every accepted pixel.
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // Stage one: the pixel whose line buffer entry is being read.
    logic             r_s1_v;
    t_pix             r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_emit;
    logic             r_s1_eof;

    // Two previous window columns, each top, middle, bottom.
    t_pix r_wc [6];

    logic              s1_go;
    logic              accept;
    logic              s1_fire;
    logic [LINE_W-1:0] rdata;
    t_pix              top;
    t_pix              mid;

    assign s1_go   = !r_s1_v || !r_s1_emit || i_win_ready;
    assign o_stall = !s1_go;
    assign accept  = i_valid && s1_go;
    assign s1_fire = r_s1_v && s1_go;

    assign top = rdata[LINE_W-1:PIX_W];
    assign mid = rdata[PIX_W-1:0];

    // The entry at column c is read on accepting its pixel and written back as that
    // pixel leaves stage one; the next read is at the following column, so the two never collide.
    mf3_ram #(
        .WIDTH(LINE_W),
        .DEPTH(IMAGE_WIDTH)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (s1_fire),
        .i_waddr(r_s1_col),
        .i_wdata({mid, r_s1_px}),
        .i_re   (accept),
        .i_raddr(r_col),
        .o_rdata(rdata)
    );

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col == COL_W'(IMAGE_WIDTH - 1)) begin
            n_col = '0;
            if (r_row == ROW_W'(IMAGE_HEIGHT - 1)) begin
                n_row = '0;
            end else begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_wc[k] <= '0;
            end
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (s1_go) begin
                r_s1_v <= i_valid;
            end
            if (s1_fire) begin
                r_wc[0] <= r_wc[3];
                r_wc[1] <= r_wc[4];
                r_wc[2] <= r_wc[5];
                r_wc[3] <= top;
                r_wc[4] <= mid;
                r_wc[5] <= r_s1_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px   <= i_pixel;
            r_s1_col  <= r_col;
            r_s1_emit <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_s1_eof  <= (r_row == ROW_W'(IMAGE_HEIGHT - 1)) &&
                         (r_col == COL_W'(IMAGE_WIDTH - 1));
        end
    end

    assign o_win_valid = r_s1_v && r_s1_emit;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            o_win.taps[k] = r_wc[k];
        end
        o_win.taps[6] = top;
        o_win.taps[7] = mid;
        o_win.taps[8] = r_s1_px;
        o_win.eof     = r_s1_eof;
    end

endmodule

// File: design/mf3_median.sv
module mf3_median import mf3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_win_valid,
    output logic o_win_ready,
    input  t_win i_win,
    output logic o_valid,
    input  logic i_stall,
    output t_pix o_median_value,
    output logic o_end_of_frame
);

    // Sorts three values; element 0 is the smallest.
    function automatic logic [2:0][PIX_W-1:0] sort3(t_pix a, t_pix b, t_pix c);
        t_pix x0;
        t_pix x1;
        t_pix y1;
        t_pix y2;
        logic [2:0][PIX_W-1:0] s;
        x0 = (a < b) ? a : b;
        x1 = (a < b) ? b : a;
        y1 = (x1 < c) ? x1 : c;
        y2 = (x1 < c) ? c : x1;
        s[0] = (x0 < y1) ? x0 : y1;
        s[1] = (x0 < y1) ? y1 : x0;
        s[2] = y2;
        return s;
    endfunction

    logic rdy2, rdy3, rdy4, rdyo;

    logic                   r_v2;
    t_win                   r_w2;
    logic                   r_v3;
    logic [2:0][2:0][PIX_W-1:0] r_col3;
    logic                   r_eof3;
    logic                   r_v4;
    t_pix                   r_lo4, r_md4, r_hi4;
    logic                   r_eof4;
    logic                   r_vo;
    t_pix                   r_med;
    logic                   r_eofo;

    logic [2:0][PIX_W-1:0]  srt_lo, srt_md, srt_hi, srt_fin;

    assign rdyo = !r_vo || !i_stall;
    assign rdy4 = !r_v4 || rdyo;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign o_win_ready = rdy2;

    // Median of nine: with each column sorted, the answer is the median of the
    // largest low, the median of the middles and the smallest high.
    assign srt_lo  = sort3(r_col3[0][0], r_col3[1][0], r_col3[2][0]);
    assign srt_md  = sort3(r_col3[0][1], r_col3[1][1], r_col3[2][1]);
    assign srt_hi  = sort3(r_col3[0][2], r_col3[1][2], r_col3[2][2]);
    assign srt_fin = sort3(r_lo4, r_md4, r_hi4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_win_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdyo) begin
                r_vo <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_w2 <= i_win;
        end
        if (rdy3) begin
            for (int c = 0; c < 3; c++) begin
                r_col3[c] <= sort3(r_w2.taps[3*c], r_w2.taps[3*c+1], r_w2.taps[3*c+2]);
            end
            r_eof3 <= r_w2.eof;
        end
        if (rdy4) begin
            r_lo4  <= srt_lo[2];
            r_md4  <= srt_md[1];
            r_hi4  <= srt_hi[0];
            r_eof4 <= r_eof3;
        end
        if (rdyo) begin
            r_med  <= srt_fin[1];
            r_eofo <= r_eof4;
        end
    end

    assign o_valid        = r_vo;
    assign o_median_value = r_med;
    assign o_end_of_frame = r_eofo;

endmodule

// File: verif/tb_median_filter_3x3_interior_unit.sv
// Self-checking bench for the 3x3 interior median filter.
//
// Pixels go in one per transfer in raster order. Each accepted pixel is run
// through a model of the line buffers, the window columns and the raster
// counters kept in this module. Whenever a pixel completes a window around an
// interior pixel, the model queues the median and the end-of-frame flag it
// predicts. Every median transfer at the output is compared with the oldest
// queued prediction.
module tb_median_filter_3x3_interior_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    // The median of nine taps is the one with four taps on each side of it.
    localparam int WINDOW_RANK = (TAPS - 1) / 2;
    // Give a median still on its way ample room before the verdict.
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS = 1_000_000;

    // Lengths of the random stretches that follow the directed frame. Together
    // they finish the second frame and run a little way into the third.
    localparam int DRAIN_PIXELS  = 80;
    localparam int RANDOM_PIXELS = 80;
    localparam int STEADY_PIXELS = 112;

    // Row content used for random pixels. Flat rows make ties common, while
    // salt and pepper rows push the extremes into otherwise smooth regions.
    typedef enum {
        TEXTURE_UNIFORM,
        TEXTURE_FLAT,
        TEXTURE_SALT_PEPPER,
        TEXTURE_EXTREME
    } t_texture;

    typedef struct {
        t_pix median;
        logic eof;
    } t_median_due;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_pix i_pixel = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_pix o_median_value;
    logic o_end_of_frame;

    // Model state. The line buffers start at zero here; their entries only
    // reach the window on the first two rows, which never yield a median.
    t_pix one_row_up [IMAGE_WIDTH] = '{default: '0};
    t_pix two_rows_up [IMAGE_WIDTH] = '{default: '0};
    t_pix window_cols [6] = '{default: '0};
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;

    t_median_due medians_due [$];
    int error_count = 0;

    // When set, neither the pixel source nor the median sink holds back.
    bit steady_flow = 1'b0;
    int stall_left = 0;

    median_filter_3x3_interior_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_median_value (o_median_value),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Picks the tap that has at most four taps below it and more than four
    // at or below it. Ties resolve to the same value a full sort would give.
    function automatic t_pix median_of_window(input t_pix taps [TAPS]);
        int below;
        int not_above;
        t_pix result = '0;
        for (int i = 0; i < TAPS; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < TAPS; j++) begin
                if (taps[j] < taps[i]) below++;
                if (taps[j] <= taps[i]) not_above++;
            end
            if (below <= WINDOW_RANK && not_above > WINDOW_RANK) result = taps[i];
        end
        return result;
    endfunction

    // Moves the model on by one accepted pixel and queues the median that
    // the pixel completes, if it completes one.
    function automatic void advance_window(input t_pix px);
        t_pix top;
        t_pix mid;
        t_pix taps [TAPS];
        t_median_due due;
        top = two_rows_up[col_pos];
        mid = one_row_up[col_pos];
        two_rows_up[col_pos] = mid;
        one_row_up[col_pos] = px;

        // On the first two columns of a row the window columns still hold the
        // end of the row above, but no median is produced there.
        if (row_pos >= 2 && col_pos >= 2) begin
            taps = '{window_cols[0], window_cols[1], window_cols[2],
                     window_cols[3], window_cols[4], window_cols[5],
                     top, mid, px};
            due.median = median_of_window(taps);
            due.eof = (row_pos == IMAGE_HEIGHT - 1) && (col_pos == IMAGE_WIDTH - 1);
            medians_due.push_back(due);
        end

        window_cols[0] = window_cols[3];
        window_cols[1] = window_cols[4];
        window_cols[2] = window_cols[5];
        window_cols[3] = top;
        window_cols[4] = mid;
        window_cols[5] = px;

        // Both counters wrap after the last pixel, so the next frame follows
        // straight on with the line buffers carried over.
        if (col_pos == IMAGE_WIDTH - 1) begin
            col_pos = 0;
            row_pos = (row_pos == IMAGE_HEIGHT - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic t_pix random_pixel(input t_texture texture, input t_pix base);
        int level;
        case (texture)
            TEXTURE_UNIFORM: begin
                level = $urandom_range(255);
            end
            TEXTURE_FLAT: begin
                level = int'(base) + int'($urandom_range(6)) - 3;
            end
            TEXTURE_SALT_PEPPER: begin
                if ($urandom_range(99) < 15) level = $urandom_range(1) ? 255 : 0;
                else level = int'(base) + int'($urandom_range(10)) - 5;
            end
            default: begin
                level = $urandom_range(1) ? 255 : 0;
            end
        endcase
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        return t_pix'(level);
    endfunction

    // Drives one pixel and returns at the falling edge after its transfer.
    // Inputs only change on falling edges; handshakes are judged on the
    // values seen at the rising edge.
    task automatic send_pixel(input t_pix px);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 3) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_window(px);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every queued median has been seen.
    task automatic drain_medians();
        i_valid <= 1'b0;
        while (medians_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sends count pixels of random content, carrying on from wherever the
    // raster stands. A fresh texture is drawn at the first pixel and at the
    // start of every row. When pause_at is not negative, the source stops
    // before that pixel until all medians so far have come out.
    task automatic send_random_pixels(input int count, input int pause_at);
        t_texture texture;
        t_pix base;
        texture = TEXTURE_UNIFORM;
        base = '0;
        for (int n = 0; n < count; n++) begin
            if (n == 0 || col_pos == 0) begin
                texture = t_texture'($urandom_range(3));
                base = t_pix'($urandom_range(255));
            end
            if (n == pause_at) drain_medians();
            send_pixel(random_pixel(texture, base));
        end
    endtask

    // One frame of fixed content: a black band, a white band and their
    // border, a checkerboard of the two extremes, a flat gray patch with one
    // white and one black impulse, and a ramp that ends on full white.
    task automatic test_directed_frame();
        t_pix px;
        for (int r = 0; r < IMAGE_HEIGHT; r++) begin
            for (int c = 0; c < IMAGE_WIDTH; c++) begin
                if (r < 3) px = 8'd0;
                else if (r < 6) px = 8'd255;
                else if (r < 10) px = ((r + c) % 2 == 1) ? 8'd255 : 8'd0;
                else if (r == 11 && c == 7) px = 8'd255;
                else if (r == 11 && c == 9) px = 8'd0;
                else if (r < 13) px = 8'd128;
                else px = t_pix'(c * 16 + r);
                send_pixel(px);
            end
        end
        drain_medians();
    endtask

    // Random pixels with the source holding off partway through, while
    // medians are still in flight, until the output has caught up completely.
    task automatic test_drain_mid_frame();
        send_random_pixels(DRAIN_PIXELS, $urandom_range(40, DRAIN_PIXELS - 8));
        drain_medians();
    endtask

    // A stretch with no gaps on the input and no stalls on the output. It
    // starts late in a frame, so the block runs at its full rate across the
    // frame boundary.
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        send_random_pixels(STEADY_PIXELS, -1);
        steady_flow = 1'b0;
        drain_medians();
    endtask

    // Random pixels with gaps and stalls on both sides.
    task automatic test_random_pixels();
        send_random_pixels(RANDOM_PIXELS, -1);
        drain_medians();
    endtask

    // The sink stalls at random in short runs, long enough to back up to the input.
    always @(negedge i_clk) begin
        if (!i_rst_n || steady_flow) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if ($urandom_range(99) < 3) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Checks every median transfer against the oldest prediction.
    always @(posedge i_clk) begin : check_medians
        t_median_due due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (medians_due.size() == 0) begin
                $display("%0t: unexpected median transfer: expected none, got %0d eof %0b",
                         $time, o_median_value, o_end_of_frame);
                error_count++;
            end else begin
                due = medians_due.pop_front();
                if (o_median_value !== due.median) begin
                    $display("%0t: median mismatch: expected %0d, got %0d",
                             $time, due.median, o_median_value);
                    error_count++;
                end
                if (o_end_of_frame !== due.eof) begin
                    $display("%0t: end_of_frame mismatch: expected %0b, got %0b",
                             $time, due.eof, o_end_of_frame);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frame();
        test_drain_mid_frame();
        test_random_pixels();
        test_steady_flow();

        // Let any stray transfer show itself before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (medians_due.size() != 0) begin
            $display("%0t: %0d medians never arrived", $time, medians_due.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/mf3_pkg.sv
design/mf3_ram.sv
design/mf3_window.sv
design/mf3_median.sv
design/median_filter_3x3_interior_unit.sv
verif/tb_median_filter_3x3_interior_unit.sv
